// File: hdl/grid_mesh_vertex_generator_macros.svh
// ----------------------------------------------------------------------------
// Grid mesh vertex generator assertion macros
// Shared concurrent assertion forms used by the port checker.
// ----------------------------------------------------------------------------
`ifndef GRID_MESH_VERTEX_GENERATOR_MACROS_SVH
`define GRID_MESH_VERTEX_GENERATOR_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define GMVG_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define GMVG_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hdl/gmvg_pkg.sv
// ----------------------------------------------------------------------------
// Grid mesh vertex generator package
// Shared types, register indexes, reset values and sizing constants.
// ----------------------------------------------------------------------------
package gmvg_pkg;

    // Default limit on the cell count of one axis.
    localparam int MAX_CELLS_DEF = 256;

    // Configuration port index width and register indexes.
    localparam int CFG_IDX_W = 3;
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_POS_TL    = 3'd0,
        CFG_POS_BR    = 3'd1,
        CFG_UV_ORIGIN = 3'd2,
        CFG_UV_SPAN   = 3'd3,
        CFG_GRID      = 3'd4,
        CFG_COLOR     = 3'd5
    } t_cfg_reg;

    // Reset values of the registers that do not clear to zero.
    localparam logic [15:0] GRID_CELLS_RST = 16'h0101;
    localparam logic [31:0] COLOR_RST      = 32'hFFFF_FFFF;

    // Magnitude width of every cell size dividend.
    localparam int DIV_W = 16;

    // Depth of the request queue between front and back.
    localparam int QDEPTH = 2;

    // Vertex sequence: TL, TR, BR, BR, BL, TL (bit k belongs to vertex k).
    localparam int          VTX_COUNT  = 6;
    localparam logic [2:0]  VTX_LAST   = 3'(VTX_COUNT - 1);
    localparam logic [5:0]  USE_RIGHT  = 6'b001110;
    localparam logic [5:0]  USE_BOTTOM = 6'b011100;

    // Cell size divider sequencing.
    typedef enum logic [1:0] {
        CALC_IDLE,
        CALC_LAUNCH,
        CALC_WAIT
    } t_calc_state;

    typedef enum logic [1:0] {
        SZ_CELL_W,
        SZ_CELL_H,
        SZ_UV_W,
        SZ_UV_H
    } t_size_sel;

    // One queued request: the cell to emit.
    typedef struct packed {
        logic [7:0] col;
        logic [7:0] row;
    } t_cell;

    // Queue status seen by both sides.
    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

    // Grid origin values used by the back end.
    typedef struct packed {
        logic signed [15:0] tlx;
        logic signed [15:0] tly;
        logic signed [15:0] u0;
        logic signed [15:0] v0;
        logic        [31:0] color;
    } t_grid_cfg;

    // Per-cell steps derived from the configuration.
    typedef struct packed {
        logic signed [16:0] cw;
        logic signed [16:0] ch;
        logic signed [16:0] uw;
        logic signed [16:0] uh;
    } t_cell_size;

endpackage

// File: hdl/grid_mesh_vertex_generator.sv
// ----------------------------------------------------------------------------
// Grid mesh vertex generator
// Turns grid cell requests into the six vertices of two triangles.
// ----------------------------------------------------------------------------
// Usage:
//   Configuration is written through i_cfg_valid / i_cfg_index / i_cfg_data;
//   o_cfg_ready is always high. Every write recomputes the cell width, cell
//   height and UV steps with one shared bit-serial divider: four divisions
//   in turn, so o_busy stays high until the last division is stored.
//   A request is accepted at a rising edge with i_start high and o_busy low;
//   i_cell_col and i_cell_row name the cell. Requests enter a two-entry
//   queue, so o_busy also rises when that queue is full.
//   The first vertex reaches the outputs through the queue, the three
//   corner stages and the output registers; the six vertices (TL, TR, BR,
//   BR, BL, TL) follow on consecutive cycles, each marked by o_strobe, the
//   sixth with o_last_vertex. Cells can go out back to back, set by the
//   single vertex port; the three-stage corner pipeline overlaps with
//   emission of the previous cell. The receiver cannot stall the outputs.
//   Reset (synchronous, active low) restores the register defaults, clears
//   the queue and the pipeline, and leaves the block ready at once.
// ----------------------------------------------------------------------------
module grid_mesh_vertex_generator #(
    parameter int MAX_CELLS_PER_AXIS = gmvg_pkg::MAX_CELLS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_start,
    output logic                            o_busy,
    input  logic [7:0]                      i_cell_col,
    input  logic [7:0]                      i_cell_row,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [gmvg_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [31:0]                     i_cfg_data,
    output logic                            o_strobe,
    output logic signed [15:0]              o_vert_x,
    output logic signed [15:0]              o_vert_y,
    output logic signed [15:0]              o_tex_u,
    output logic signed [15:0]              o_tex_v,
    output logic [31:0]                     o_vert_color,
    output logic                            o_last_vertex
);
    import gmvg_pkg::*;

    logic       push, pop;
    t_cell      push_cell, head_cell;
    t_q_status  q_status;
    t_grid_cfg  grid;
    t_cell_size size;

    assign o_cfg_ready = 1'b1;

    // Configuration, cell sizing and request acceptance.
    gmvg_front #(
        .MAX_CELLS (MAX_CELLS_PER_AXIS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_start     (i_start),
        .i_cell_col  (i_cell_col),
        .i_cell_row  (i_cell_row),
        .i_q_status  (q_status),
        .o_busy      (o_busy),
        .o_push      (push),
        .o_cell      (push_cell),
        .o_grid      (grid),
        .o_size      (size)
    );

    // Request queue decoupling the two ends.
    gmvg_cell_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_cell   (push_cell),
        .i_pop    (pop),
        .o_cell   (head_cell),
        .o_status (q_status)
    );

    // Corner computation and vertex emission.
    gmvg_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_status    (q_status),
        .i_cell        (head_cell),
        .i_grid        (grid),
        .i_size        (size),
        .o_pop         (pop),
        .o_strobe      (o_strobe),
        .o_vert_x      (o_vert_x),
        .o_vert_y      (o_vert_y),
        .o_tex_u       (o_tex_u),
        .o_tex_v       (o_tex_v),
        .o_vert_color  (o_vert_color),
        .o_last_vertex (o_last_vertex)
    );

endmodule

// File: hdl/gmvg_divider.sv
// ----------------------------------------------------------------------------
// Grid mesh vertex generator divider
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module gmvg_divider #(
    parameter int DIVISOR_W = 9
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [gmvg_pkg::DIV_W-1:0]  i_dividend,
    input  logic [DIVISOR_W-1:0]        i_divisor,
    output logic                        o_done,
    output logic [gmvg_pkg::DIV_W-1:0]  o_quotient
);
    import gmvg_pkg::*;

    localparam int CNT_W = $clog2(DIV_W);

    logic                 r_busy;
    logic                 r_done;
    logic [CNT_W-1:0]     r_cnt;
    logic [DIVISOR_W-1:0] r_rem;
    logic [DIV_W-1:0]     r_quo;

    logic [DIVISOR_W:0]   rem_sh;
    logic [DIVISOR_W:0]   rem_sub;
    logic                 take;

    // Shift in the next dividend bit and try to subtract the divisor.
    always_comb begin
        rem_sh  = {r_rem, r_quo[DIV_W-1]};
        take    = (rem_sh >= {1'b0, i_divisor});
        rem_sub = rem_sh - {1'b0, i_divisor};
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + 1'b1;
            if (r_cnt == CNT_W'(DIV_W - 1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end else begin
            r_done <= 1'b0;
        end
    end

    // Remainder and quotient shift register.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
        end else if (r_busy) begin
            r_rem <= take ? rem_sub[DIVISOR_W-1:0] : rem_sh[DIVISOR_W-1:0];
            r_quo <= {r_quo[DIV_W-2:0], take};
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

// File: hdl/gmvg_front.sv
// ----------------------------------------------------------------------------
// Grid mesh vertex generator front end
// Holds the configuration, derives the cell sizes and accepts requests.
// ----------------------------------------------------------------------------
module gmvg_front #(
    parameter int MAX_CELLS = gmvg_pkg::MAX_CELLS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_valid,
    input  logic [gmvg_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [31:0]                     i_cfg_data,
    input  logic                            i_start,
    input  logic [7:0]                      i_cell_col,
    input  logic [7:0]                      i_cell_row,
    input  gmvg_pkg::t_q_status             i_q_status,
    output logic                            o_busy,
    output logic                            o_push,
    output gmvg_pkg::t_cell                 o_cell,
    output gmvg_pkg::t_grid_cfg             o_grid,
    output gmvg_pkg::t_cell_size            o_size
);
    import gmvg_pkg::*;

    localparam int CNT_W = $clog2(MAX_CELLS + 1);

    // Configuration registers.
    logic [31:0] r_pos_tl;
    logic [31:0] r_pos_br;
    logic [31:0] r_uv_org;
    logic [31:0] r_uv_span;
    logic [15:0] r_grid;
    logic [31:0] r_color;

    // Cell size sequencer.
    t_calc_state        r_state, n_state;
    t_size_sel          r_sel, n_sel;
    logic signed [16:0] r_cw, r_ch, r_uw, r_uh;

    logic               store;
    logic [CNT_W-1:0]   cnt_x, cnt_y;
    logic [CNT_W-1:0]   divisor;
    logic signed [16:0] dividend;
    logic               neg;
    logic [16:0]        mag;
    logic               div_done;
    logic [DIV_W-1:0]   div_quo;
    logic signed [16:0] quo_signed;

    // Register writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos_tl  <= '0;
            r_pos_br  <= '0;
            r_uv_org  <= '0;
            r_uv_span <= '0;
            r_grid    <= GRID_CELLS_RST;
            r_color   <= COLOR_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_POS_TL:    r_pos_tl  <= i_cfg_data;
                CFG_POS_BR:    r_pos_br  <= i_cfg_data;
                CFG_UV_ORIGIN: r_uv_org  <= i_cfg_data;
                CFG_UV_SPAN:   r_uv_span <= i_cfg_data;
                CFG_GRID:      r_grid    <= i_cfg_data[15:0];
                CFG_COLOR:     r_color   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Effective counts: zero is used as one, large counts are clipped.
    always_comb begin
        if (r_grid[7:0] == 8'd0) begin
            cnt_x = CNT_W'(1);
        end else if ({1'b0, r_grid[7:0]} > 9'(MAX_CELLS)) begin
            cnt_x = CNT_W'(MAX_CELLS);
        end else begin
            cnt_x = CNT_W'(r_grid[7:0]);
        end
        if (r_grid[15:8] == 8'd0) begin
            cnt_y = CNT_W'(1);
        end else if ({1'b0, r_grid[15:8]} > 9'(MAX_CELLS)) begin
            cnt_y = CNT_W'(MAX_CELLS);
        end else begin
            cnt_y = CNT_W'(r_grid[15:8]);
        end
    end

    // Operand selection for the current size; the divisor is always positive.
    always_comb begin
        case (r_sel)
            SZ_CELL_W: begin
                dividend = {r_pos_br[15], r_pos_br[15:0]} - {r_pos_tl[15], r_pos_tl[15:0]};
                divisor  = cnt_x;
            end
            SZ_CELL_H: begin
                dividend = {r_pos_tl[31], r_pos_tl[31:16]}
                         - {r_pos_br[31], r_pos_br[31:16]};
                divisor  = cnt_y;
            end
            SZ_UV_W: begin
                dividend = {r_uv_span[15], r_uv_span[15:0]};
                divisor  = cnt_x;
            end
            SZ_UV_H: begin
                dividend = {r_uv_span[31], r_uv_span[31:16]};
                divisor  = cnt_y;
            end
            default: begin
                dividend = '0;
                divisor  = cnt_x;
            end
        endcase
        neg        = dividend[16];
        mag        = neg ? (17'd0 - dividend) : dividend;
        quo_signed = neg ? (17'sd0 - $signed({1'b0, div_quo})) : $signed({1'b0, div_quo});
    end

    gmvg_divider #(
        .DIVISOR_W (CNT_W)
    ) u_divider (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_state == CALC_LAUNCH),
        .i_dividend (mag[DIV_W-1:0]),
        .i_divisor  (divisor),
        .o_done     (div_done),
        .o_quotient (div_quo)
    );

    // Sequencer state register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= CALC_IDLE;
            r_sel   <= SZ_CELL_W;
        end else begin
            r_state <= n_state;
            r_sel   <= n_sel;
        end
    end

    // Any register write restarts the four divisions.
    always_comb begin
        n_state = r_state;
        n_sel   = r_sel;
        store   = 1'b0;
        if (i_cfg_valid) begin
            n_state = CALC_LAUNCH;
            n_sel   = SZ_CELL_W;
        end else begin
            case (r_state)
                CALC_IDLE:   n_state = CALC_IDLE;
                CALC_LAUNCH: n_state = CALC_WAIT;
                CALC_WAIT: begin
                    if (div_done) begin
                        store = 1'b1;
                        case (r_sel)
                            SZ_CELL_W: begin
                                n_sel   = SZ_CELL_H;
                                n_state = CALC_LAUNCH;
                            end
                            SZ_CELL_H: begin
                                n_sel   = SZ_UV_W;
                                n_state = CALC_LAUNCH;
                            end
                            SZ_UV_W: begin
                                n_sel   = SZ_UV_H;
                                n_state = CALC_LAUNCH;
                            end
                            default: n_state = CALC_IDLE;
                        endcase
                    end
                end
                default: n_state = CALC_IDLE;
            endcase
        end
    end

    // Cell size registers; zero matches the reset geometry.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cw <= '0;
            r_ch <= '0;
            r_uw <= '0;
            r_uh <= '0;
        end else if (store) begin
            case (r_sel)
                SZ_CELL_W: r_cw <= quo_signed;
                SZ_CELL_H: r_ch <= quo_signed;
                SZ_UV_W:   r_uw <= quo_signed;
                SZ_UV_H:   r_uh <= quo_signed;
                default: ;
            endcase
        end
    end

    // Request acceptance into the queue.
    assign o_busy     = (r_state != CALC_IDLE) || i_q_status.full;
    assign o_push     = i_start && !o_busy;
    assign o_cell.col = i_cell_col;
    assign o_cell.row = i_cell_row;

    assign o_grid.tlx   = r_pos_tl[15:0];
    assign o_grid.tly   = r_pos_tl[31:16];
    assign o_grid.u0    = r_uv_org[15:0];
    assign o_grid.v0    = r_uv_org[31:16];
    assign o_grid.color = r_color;

    assign o_size.cw = r_cw;
    assign o_size.ch = r_ch;
    assign o_size.uw = r_uw;
    assign o_size.uh = r_uh;

endmodule

// File: hdl/gmvg_cell_queue.sv
// ----------------------------------------------------------------------------
// Grid mesh vertex generator request queue
// Small FIFO of cell requests between the front and back ends.
// ----------------------------------------------------------------------------
module gmvg_cell_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  gmvg_pkg::t_cell   i_cell,
    input  logic              i_pop,
    output gmvg_pkg::t_cell   o_cell,
    output gmvg_pkg::t_q_status o_status
);
    import gmvg_pkg::*;

    localparam int PTR_W   = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int COUNT_W = $clog2(QDEPTH + 1);

    t_cell              r_mem [QDEPTH];
    logic [PTR_W-1:0]   r_wr_ptr;
    logic [PTR_W-1:0]   r_rd_ptr;
    logic [COUNT_W-1:0] r_count;

    logic do_push, do_pop;

    assign do_push = i_push && (r_count != COUNT_W'(QDEPTH));
    assign do_pop  = i_pop && (r_count != '0);

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(QDEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(QDEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_cell;
        end
    end

    assign o_cell          = r_mem[r_rd_ptr];
    assign o_status.full   = (r_count == COUNT_W'(QDEPTH));
    assign o_status.empty  = (r_count == '0);

endmodule

// File: hdl/gmvg_back.sv
// ----------------------------------------------------------------------------
// Grid mesh vertex generator back end
// Computes the cell corners in three stages and emits six vertices.
// ----------------------------------------------------------------------------
module gmvg_back (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  gmvg_pkg::t_q_status     i_q_status,
    input  gmvg_pkg::t_cell         i_cell,
    input  gmvg_pkg::t_grid_cfg     i_grid,
    input  gmvg_pkg::t_cell_size    i_size,
    output logic                    o_pop,
    output logic                    o_strobe,
    output logic signed [15:0]      o_vert_x,
    output logic signed [15:0]      o_vert_y,
    output logic signed [15:0]      o_tex_u,
    output logic signed [15:0]      o_tex_v,
    output logic [31:0]             o_vert_color,
    output logic                    o_last_vertex
);
    import gmvg_pkg::*;

    // Clamp an exact coordinate to the signed 16-bit range.
    function automatic logic [15:0] sat16(input logic signed [27:0] v);
        if (v > 28'sd32767) begin
            return 16'h7FFF;
        end else if (v < -28'sd32768) begin
            return 16'h8000;
        end else begin
            return v[15:0];
        end
    endfunction

    logic signed [16:0] cw, ch, uw, uh;
    logic signed [15:0] tlx, tly, u0, v0;

    // Stage one: the request taken from the queue.
    logic       r_s1_valid;
    logic [7:0] r_s1_col, r_s1_row;

    // Stage two: index times step products.
    logic               r_s2_valid;
    logic signed [25:0] r_px, r_py, r_pu, r_pv;
    logic signed [25:0] n_px, n_py, n_pu, n_pv;

    // Stage three: the eight corner coordinates, held while emitting.
    logic        r_s3_valid;
    logic [2:0]  r_vtx;
    logic [15:0] r_xl, r_xr, r_yt, r_yb, r_ul, r_ur, r_vt, r_vb;

    logic signed [27:0] xl, xr, yt, yb, ul, ur, vt, vb;

    // Output registers.
    logic        r_strobe, r_last;
    logic [15:0] r_x, r_y, r_u, r_v;
    logic [31:0] r_color;

    logic s3_done, s3_free, s2_move, s2_free, s1_move, s1_free;

    assign cw  = i_size.cw;
    assign ch  = i_size.ch;
    assign uw  = i_size.uw;
    assign uh  = i_size.uh;
    assign tlx = i_grid.tlx;
    assign tly = i_grid.tly;
    assign u0  = i_grid.u0;
    assign v0  = i_grid.v0;

    // Stage handshakes: each stage moves when the one after it frees up.
    assign s3_done = r_s3_valid && (r_vtx == VTX_LAST);
    assign s3_free = !r_s3_valid || s3_done;
    assign s2_move = r_s2_valid && s3_free;
    assign s2_free = !r_s2_valid || s3_free;
    assign s1_move = r_s1_valid && s2_free;
    assign s1_free = !r_s1_valid || s2_free;
    assign o_pop   = !i_q_status.empty && s1_free;

    // Products of the cell index and the per-cell step.
    always_comb begin
        n_px = $signed({1'b0, r_s1_col}) * cw;
        n_py = $signed({1'b0, r_s1_row}) * ch;
        n_pu = $signed({1'b0, r_s1_col}) * uw;
        n_pv = $signed({1'b0, r_s1_row}) * uh;
    end

    // Near and far edges; y runs downward as the row grows.
    always_comb begin
        xl = 28'(tlx) + 28'(r_px);
        xr = xl + 28'(cw);
        yt = 28'(tly) - 28'(r_py);
        yb = yt - 28'(ch);
        ul = 28'(u0) + 28'(r_pu);
        ur = ul + 28'(uw);
        vt = 28'(v0) + 28'(r_pv);
        vb = vt + 28'(uh);
    end

    // Stage valid bits and the vertex counter.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_s3_valid <= 1'b0;
            r_vtx      <= '0;
            r_strobe   <= 1'b0;
            r_last     <= 1'b0;
        end else begin
            if (s1_free) begin
                r_s1_valid <= o_pop;
            end
            if (s2_free) begin
                r_s2_valid <= s1_move;
            end
            if (s3_free) begin
                r_s3_valid <= s2_move;
            end
            if (r_s3_valid) begin
                r_vtx <= s3_done ? '0 : r_vtx + 1'b1;
            end
            r_strobe <= r_s3_valid;
            r_last   <= s3_done;
        end
    end

    // Stage payloads.
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_s1_col <= i_cell.col;
            r_s1_row <= i_cell.row;
        end
        if (s1_move) begin
            r_px <= n_px;
            r_py <= n_py;
            r_pu <= n_pu;
            r_pv <= n_pv;
        end
        if (s2_move) begin
            r_xl <= sat16(xl);
            r_xr <= sat16(xr);
            r_yt <= sat16(yt);
            r_yb <= sat16(yb);
            r_ul <= sat16(ul);
            r_ur <= sat16(ur);
            r_vt <= sat16(vt);
            r_vb <= sat16(vb);
        end
    end

    // Pick the corner of the current vertex.
    always_ff @(posedge i_clk) begin
        if (r_s3_valid) begin
            r_x     <= USE_RIGHT[r_vtx]  ? r_xr : r_xl;
            r_u     <= USE_RIGHT[r_vtx]  ? r_ur : r_ul;
            r_y     <= USE_BOTTOM[r_vtx] ? r_yb : r_yt;
            r_v     <= USE_BOTTOM[r_vtx] ? r_vb : r_vt;
            r_color <= i_grid.color;
        end
    end

    assign o_strobe      = r_strobe;
    assign o_vert_x      = r_x;
    assign o_vert_y      = r_y;
    assign o_tex_u       = r_u;
    assign o_tex_v       = r_v;
    assign o_vert_color  = r_color;
    assign o_last_vertex = r_last;

endmodule

// File: hdl/gmvg_checker.sv
// ----------------------------------------------------------------------------
// Grid mesh vertex generator port checker
// Watches the vertex outputs for a well-formed six-vertex sequence.
// ----------------------------------------------------------------------------
`include "grid_mesh_vertex_generator_macros.svh"

module gmvg_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_strobe,
    input  logic        i_last_vertex,
    input  logic [15:0] i_vert_x,
    input  logic [15:0] i_vert_y,
    input  logic [31:0] i_vert_color
);

    // The last-vertex mark only comes with a vertex.
    `GMVG_ASSERT_IMPLY(a_last_has_strobe, i_clk, i_rst_n, i_last_vertex, i_strobe, "last vertex without strobe")

    // The vertices of one cell come on consecutive cycles.
    `GMVG_ASSERT_NEXT(a_cell_unbroken, i_clk, i_rst_n, i_strobe && !i_last_vertex, i_strobe, "cell vertex sequence broken")

    // The closing vertex returns to the opening top-left corner.
    `GMVG_ASSERT_IMPLY(a_cell_closes, i_clk, i_rst_n, i_last_vertex, $past(i_strobe, 5) && i_vert_x == $past(i_vert_x, 5) && i_vert_y == $past(i_vert_y, 5), "last vertex is not the first corner")

    // The color does not change inside one cell.
    `GMVG_ASSERT_IMPLY(a_color_steady, i_clk, i_rst_n, i_strobe && $past(i_strobe) && !$past(i_last_vertex), i_vert_color == $past(i_vert_color), "color changed within a cell")

endmodule

bind grid_mesh_vertex_generator gmvg_checker u_gmvg_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_strobe      (o_strobe),
    .i_last_vertex (o_last_vertex),
    .i_vert_x      (o_vert_x),
    .i_vert_y      (o_vert_y),
    .i_vert_color  (o_vert_color)
);
